// ----- hw/rtl/sorted_sparse_term_table_unit_assert.svh -----
// assertion macros for the sorted sparse term table
// used by sorted_sparse_term_table_unit, needs clk and rst_n in scope
`ifndef SORTED_SPARSE_TERM_TABLE_UNIT_ASSERT_SVH
`define SORTED_SPARSE_TERM_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define SSTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sstt_pkg.sv -----
// shared types and constants for the sorted sparse term table
// no dependencies
package sstt_pkg;

  localparam int unsigned SSTT_MAX_TERMS = 64;
  localparam int unsigned SSTT_DATA_W    = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } sstt_cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_FULL  = 3'd2,
    ST_RANGE = 3'd3,
    ST_SAT   = 3'd4
  } sstt_status_t;

  typedef enum logic {
    ARITH_CMP = 1'b0,
    ARITH_ADD = 1'b1
  } sstt_arith_op_t;

  typedef struct packed {
    logic                   gt;
    logic                   eq;
    logic                   sat;
    logic                   zero;
    logic [SSTT_DATA_W-1:0] value;
  } sstt_arith_res_t;

  typedef struct packed {
    logic [SSTT_DATA_W-1:0] coef;
    logic [SSTT_DATA_W-1:0] expo;
  } sstt_term_t;

endpackage

// ----- hw/rtl/sorted_sparse_term_table_unit.sv -----
// sorted sparse term table, top level: sequencer and term memory
// depends on sstt_pkg, sstt_arith and sorted_sparse_term_table_unit_assert.svh
//
// An item is taken when start is high and busy is low; its result appears
// on the out_ ports for exactly one cycle with out_valid high, and the
// receiver cannot stall it. Clear, zero-coefficient push, out-of-range read
// and the unused command answer in the cycle after start without raising busy.
// A read issues the memory read from idle and answers from S_RD_OUT. A push
// walks the table one entry at a time (S_SRCH_RD, S_SRCH_CHK) through a single
// read port of the term memory and one shared adder. To insert, or to drop a
// term summed to zero, it moves entries one at a time (a read, then a write).
`include "sorted_sparse_term_table_unit_assert.svh"

module sorted_sparse_term_table_unit #(
  parameter int unsigned MAX_TERMS = sstt_pkg::SSTT_MAX_TERMS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_new_coefficient,
  input  logic signed [31:0] in_new_exponent,
  input  logic [5:0]         in_term_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [6:0]         out_term_count,
  output logic signed [31:0] out_read_coefficient,
  output logic signed [31:0] out_read_exponent
);
  import sstt_pkg::*;

  localparam int unsigned ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TERMS + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RD_OUT   = 9'b000000010,
    S_SRCH_RD  = 9'b000000100,
    S_SRCH_CHK = 9'b000001000,
    S_MERGE    = 9'b000010000,
    S_DEL_RD   = 9'b000100000,
    S_DEL_WR   = 9'b001000000,
    S_INS_RD   = 9'b010000000,
    S_INS_WR   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [31:0]        coef_r, coef_nxt;
  logic [31:0]        exp_r, exp_nxt;
  sstt_term_t         rd_r;

  logic               out_valid_r, out_valid_nxt;
  sstt_status_t       out_status_r, out_status_nxt;
  logic [6:0]         out_count_r, out_count_nxt;
  logic [31:0]        out_rc_r, out_rc_nxt;
  logic [31:0]        out_re_r, out_re_nxt;

  sstt_term_t         mem [MAX_TERMS];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  sstt_term_t         mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  sstt_arith_op_t     arith_op;
  logic [31:0]        arith_a;
  logic [31:0]        arith_b;
  sstt_arith_res_t    arith_res;

  logic               done;
  logic [CNT_W-1:0]   ptr_inc;
  logic [CNT_W-1:0]   ptr_dec;
  logic [CNT_W+6:0]   count_ext;
  logic               idx_ok;

  sstt_arith u_arith (
    .op  (arith_op),
    .a   (arith_a),
    .b   (arith_b),
    .res (arith_res)
  );

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_term_count       = out_count_r;
  assign out_read_coefficient = out_rc_r;
  assign out_read_exponent    = out_re_r;

  assign ptr_inc = ptr_r + CNT_W'(1);
  assign ptr_dec = ptr_r - CNT_W'(1);
  assign idx_ok  = (32'(in_term_index) < 32'(count_r));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    coef_nxt       = coef_r;
    exp_nxt        = exp_r;
    done           = 1'b0;
    out_status_nxt = out_status_r;
    out_rc_nxt     = out_rc_r;
    out_re_nxt     = out_re_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r[ADDR_W-1:0];
    mem_wdata      = rd_r;
    mem_re         = 1'b0;
    mem_raddr      = pos_r[ADDR_W-1:0];
    arith_op       = ARITH_CMP;
    arith_a        = rd_r.expo;
    arith_b        = exp_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_cmd)
            CMD_PUSH: begin
              coef_nxt = in_new_coefficient;
              exp_nxt  = in_new_exponent;
              if (in_new_coefficient == 32'sd0) begin
                done           = 1'b1;
                out_status_nxt = ST_ZERO;
              end else begin
                pos_nxt   = '0;
                state_nxt = S_SRCH_RD;
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(in_term_index);
                state_nxt = S_RD_OUT;
              end else begin
                done           = 1'b1;
                out_status_nxt = ST_RANGE;
              end
            end
            CMD_CLEAR: begin
              count_nxt      = '0;
              done           = 1'b1;
              out_status_nxt = ST_OK;
            end
            default: begin
              done           = 1'b1;
              out_status_nxt = ST_OK;
            end
          endcase
          if (done) begin
            out_rc_nxt = '0;
            out_re_nxt = '0;
          end
        end
      end
      S_RD_OUT: begin
        done           = 1'b1;
        out_status_nxt = ST_OK;
        out_rc_nxt     = rd_r.coef;
        out_re_nxt     = rd_r.expo;
        state_nxt      = S_IDLE;
      end
      S_SRCH_RD: begin
        if (pos_r == count_r) begin
          if (count_r == CNT_W'(MAX_TERMS)) begin
            done           = 1'b1;
            out_status_nxt = ST_FULL;
            state_nxt      = S_IDLE;
          end else begin
            ptr_nxt   = count_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_r[ADDR_W-1:0];
          state_nxt = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (arith_res.gt) begin
          pos_nxt   = pos_r + CNT_W'(1);
          state_nxt = S_SRCH_RD;
        end else if (arith_res.eq) begin
          state_nxt = S_MERGE;
        end else if (count_r == CNT_W'(MAX_TERMS)) begin
          done           = 1'b1;
          out_status_nxt = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt   = count_r;
          state_nxt = S_INS_RD;
        end
      end
      S_MERGE: begin
        arith_op = ARITH_ADD;
        arith_a  = rd_r.coef;
        arith_b  = coef_r;
        if (arith_res.zero) begin
          ptr_nxt   = pos_r;
          state_nxt = S_DEL_RD;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = pos_r[ADDR_W-1:0];
          mem_wdata.coef = arith_res.value;
          mem_wdata.expo = exp_r;
          done           = 1'b1;
          out_status_nxt = arith_res.sat ? ST_SAT : ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_DEL_RD: begin
        if (ptr_inc == count_r) begin
          count_nxt      = count_r - CNT_W'(1);
          done           = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[ADDR_W-1:0];
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[ADDR_W-1:0];
        mem_wdata = rd_r;
        ptr_nxt   = ptr_inc;
        state_nxt = S_DEL_RD;
      end
      S_INS_RD: begin
        if (ptr_r == pos_r) begin
          mem_we         = 1'b1;
          mem_waddr      = pos_r[ADDR_W-1:0];
          mem_wdata.coef = coef_r;
          mem_wdata.expo = exp_r;
          count_nxt      = count_r + CNT_W'(1);
          done           = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[ADDR_W-1:0];
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[ADDR_W-1:0];
        mem_wdata = rd_r;
        ptr_nxt   = ptr_dec;
        state_nxt = S_INS_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done && (state_r != S_IDLE) && (state_r != S_RD_OUT)) begin
      out_rc_nxt = '0;
      out_re_nxt = '0;
    end
    out_valid_nxt = done;
    count_ext     = {7'd0, count_nxt};
    out_count_nxt = done ? count_ext[6:0] : out_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    coef_r       <= coef_nxt;
    exp_r        <= exp_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_rc_r     <= out_rc_nxt;
    out_re_r     <= out_re_nxt;
  end

  // term memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  `SSTT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_TERMS), "term count above capacity")
  `SSTT_ASSERT_NOW(a_no_result_busy, busy, !out_valid, "result strobe while busy")
  `SSTT_ASSERT_NOW(a_write_busy, mem_we, state_r != S_IDLE, "memory write while idle")
  `SSTT_ASSERT_NEXT(a_count_step, !(start && !busy && (in_cmd == CMD_CLEAR)), (count_r == $past(count_r)) || (count_r == $past(count_r) + 1) || (count_r + 1 == $past(count_r)), "count moved by more than one")

endmodule

// ----- hw/rtl/sstt_arith.sv -----
// shared adder for exponent compare and saturating coefficient add
// depends on sstt_pkg
module sstt_arith (
  input  sstt_pkg::sstt_arith_op_t  op,
  input  logic signed [31:0]        a,
  input  logic signed [31:0]        b,
  output sstt_pkg::sstt_arith_res_t res
);
  import sstt_pkg::*;

  logic [32:0] a_x;
  logic [32:0] b_x;
  logic [32:0] s;
  logic        cin;
  logic        ovf;
  logic [31:0] val;

  always_comb begin
    a_x = {a[31], a};
    cin = 1'b0;
    b_x = {b[31], b};
    case (op)
      ARITH_CMP: begin
        b_x = ~{b[31], b};
        cin = 1'b1;
      end
      ARITH_ADD: begin
        b_x = {b[31], b};
        cin = 1'b0;
      end
      default: begin
        b_x = {b[31], b};
        cin = 1'b0;
      end
    endcase
    s   = a_x + b_x + {32'd0, cin};
    ovf = s[32] ^ s[31];
    if (ovf) begin
      val = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      val = s[31:0];
    end
    res.gt    = !s[32] && (s != 33'd0);
    res.eq    = (s == 33'd0);
    res.sat   = ovf;
    res.zero  = (val == 32'd0);
    res.value = val;
  end

endmodule

// ----- tb/tb_sorted_sparse_term_table_unit.sv -----
// testbench for sorted_sparse_term_table_unit: directed and random pushes, reads, clears
// needs sstt_pkg and the rtl of sorted_sparse_term_table_unit; results checked against a local table
`timescale 1ns / 1ps

module tb_sorted_sparse_term_table_unit;
  import sstt_pkg::*;

  localparam int unsigned TERM_SLOTS = SSTT_MAX_TERMS;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic signed [31:0] INT_TOP = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT_BOTTOM = 32'sh8000_0000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int REPORT_CAP = 60;

  typedef struct {
    sstt_status_t status;
    logic [6:0] term_count;
    logic signed [31:0] read_coefficient;
    logic signed [31:0] read_exponent;
  } term_answer_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_cmd;
  logic signed [31:0] in_new_coefficient;
  logic signed [31:0] in_new_exponent;
  logic [5:0] in_term_index;
  logic out_valid;
  logic [2:0] out_status;
  logic [6:0] out_term_count;
  logic signed [31:0] out_read_coefficient;
  logic signed [31:0] out_read_exponent;

  // local copy of the term table
  logic signed [31:0] held_coef [TERM_SLOTS];
  logic signed [31:0] held_expo [TERM_SLOTS];
  int held_terms;

  term_answer_t table_answers[$];
  logic signed [31:0] expo_pool [96];
  int errors = 0;
  int answers_checked = 0;
  int cycles = 0;
  int no_gap_run;
  int cmd_seen [4];
  int status_seen [5] = '{default: 0};

  sorted_sparse_term_table_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_new_coefficient   (in_new_coefficient),
    .in_new_exponent      (in_new_exponent),
    .in_term_index        (in_term_index),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_term_count       (out_term_count),
    .out_read_coefficient (out_read_coefficient),
    .out_read_exponent    (out_read_exponent)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("sorted_sparse_term_table_unit regression: fail");
      $finish;
    end
  end

  function automatic int find_term(logic signed [31:0] e);
    int k;
    for (k = 0; k < held_terms; k++) begin
      if (held_expo[k] == e) return k;
    end
    return -1;
  endfunction

  function automatic term_answer_t apply_term_op(logic [1:0] cmd, logic signed [31:0] c,
                                                 logic signed [31:0] e, logic [5:0] idx);
    term_answer_t r;
    int pos;
    int k;
    longint sum;
    r.status = ST_OK;
    r.read_coefficient = '0;
    r.read_exponent = '0;
    if (cmd == CMD_PUSH) begin
      if (c == 0) begin
        r.status = ST_ZERO;
      end else begin
        pos = 0;
        while (pos < held_terms && held_expo[pos] > e) pos++;
        if (pos < held_terms && held_expo[pos] == e) begin
          sum = longint'(held_coef[pos]) + longint'(c);
          if (sum > longint'(INT_TOP)) begin
            sum = longint'(INT_TOP);
            r.status = ST_SAT;
          end else if (sum < longint'(INT_BOTTOM)) begin
            sum = longint'(INT_BOTTOM);
            r.status = ST_SAT;
          end
          if (sum == 0) begin
            for (k = pos; k + 1 < held_terms; k++) begin
              held_coef[k] = held_coef[k + 1];
              held_expo[k] = held_expo[k + 1];
            end
            held_terms--;
          end else begin
            held_coef[pos] = 32'(sum);
          end
        end else if (held_terms >= TERM_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          for (k = held_terms; k > pos; k--) begin
            held_coef[k] = held_coef[k - 1];
            held_expo[k] = held_expo[k - 1];
          end
          held_coef[pos] = c;
          held_expo[pos] = e;
          held_terms++;
        end
      end
    end else if (cmd == CMD_READ) begin
      if (int'(idx) < held_terms) begin
        r.read_coefficient = held_coef[idx];
        r.read_exponent = held_expo[idx];
      end else begin
        r.status = ST_RANGE;
      end
    end else if (cmd == CMD_CLEAR) begin
      held_terms = 0;
    end
    r.term_count = 7'(held_terms);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] c,
                           input logic signed [31:0] e, input logic [5:0] idx);
    int gap;
    term_answer_t want;
    if (no_gap_run == 0 && $urandom_range(0, 11) == 0) no_gap_run = $urandom_range(5, 30);
    if (no_gap_run > 0) begin
      gap = 0;
      no_gap_run--;
    end else begin
      gap = $urandom_range(0, 8);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= cmd;
    in_new_coefficient <= c;
    in_new_exponent <= e;
    in_term_index <= idx;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    cmd_seen[cmd]++;
    want = apply_term_op(cmd, c, e, idx);
    table_answers = {table_answers, want};
  endtask

  task automatic wait_table_idle();
    start <= 1'b0;
    while (table_answers.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin : check_answers
    term_answer_t want;
    if (rst_n && out_valid) begin
      if (table_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, out_status, out_term_count);
      end else begin
        want = table_answers.pop_front();
        answers_checked++;
        status_seen[want.status]++;
        if (out_status !== want.status)
          report_field("status", 32'(want.status), 32'(out_status));
        if (out_term_count !== want.term_count)
          report_field("term_count", 32'(want.term_count), 32'(out_term_count));
        if (out_read_coefficient !== want.read_coefficient)
          report_field("read_coefficient", want.read_coefficient, out_read_coefficient);
        if (out_read_exponent !== want.read_exponent)
          report_field("read_exponent", want.read_exponent, out_read_exponent);
      end
    end
  end

  function automatic logic signed [31:0] pick_exponent();
    if ($urandom_range(0, 9) < 8) return expo_pool[$urandom_range(0, 95)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_coefficient(logic signed [31:0] e);
    int sel;
    int pos;
    sel = $urandom_range(0, 99);
    pos = find_term(e);
    if (sel < 5) return '0;
    if (sel < 22 && pos >= 0) return -held_coef[pos];
    if (sel < 32) return $urandom_range(0, 1) ? INT_TOP : INT_BOTTOM;
    if (sel < 60) return $urandom;
    return int'($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic logic [5:0] pick_index();
    if (held_terms == 0 || $urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, held_terms - 1));
  endfunction

  task automatic reset_block();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_empty_table();
    send_item(CMD_READ, $urandom, $urandom, 6'd0);
    send_item(CMD_READ, $urandom, $urandom, 6'd63);
    send_item(CMD_SPARE, $urandom, $urandom, 6'($urandom_range(0, 63)));
    send_item(CMD_CLEAR, $urandom, $urandom, 6'($urandom_range(0, 63)));
    send_item(CMD_PUSH, '0, 32'sd5, 6'd0);
    wait_table_idle();
  endtask

  task automatic test_push_extremes();
    send_item(CMD_PUSH, INT_TOP, INT_TOP, 6'd0);
    send_item(CMD_PUSH, INT_BOTTOM, INT_BOTTOM, 6'd63);
    send_item(CMD_PUSH, 32'sd1, 32'sd0, 6'd0);
    send_item(CMD_PUSH, -32'sd1, -32'sd1, 6'd0);
    send_item(CMD_PUSH, INT_TOP, INT_TOP, 6'd0);
    send_item(CMD_PUSH, -32'sd1, INT_BOTTOM, 6'd0);
    send_item(CMD_PUSH, -32'sd1, 32'sd0, 6'd0);
    send_item(CMD_PUSH, 32'sd9, 32'sd7, 6'd0);
    send_item(CMD_SPARE, INT_TOP, INT_TOP, 6'd1);
    send_item(CMD_READ, '0, '0, 6'd0);
    send_item(CMD_READ, '0, '0, 6'd1);
    send_item(CMD_READ, '0, '0, 6'd2);
    send_item(CMD_READ, '0, '0, 6'd3);
    send_item(CMD_READ, '0, '0, 6'd4);
    send_item(CMD_PUSH, '0, INT_TOP, 6'd0);
    send_item(CMD_PUSH, INT_BOTTOM, INT_TOP, 6'd0);
    send_item(CMD_READ, '0, '0, 6'd0);
    send_item(CMD_CLEAR, '0, '0, 6'd0);
    send_item(CMD_READ, '0, '0, 6'd0);
    wait_table_idle();
  endtask

  // fill to capacity, then push new and existing exponents against a full table
  task automatic test_full_table();
    logic signed [31:0] e;
    int pos;
    while (held_terms < TERM_SLOTS) begin
      e = $urandom_range(0, 1) ? int'($urandom) : pick_exponent();
      if (find_term(e) < 0) send_item(CMD_PUSH, pick_coefficient(e) | 32'sd1, e, 6'($urandom));
    end
    do e = $urandom; while (find_term(e) >= 0);
    send_item(CMD_PUSH, INT_TOP, e, 6'($urandom));
    pos = $urandom_range(0, TERM_SLOTS - 1);
    send_item(CMD_PUSH, INT_TOP, held_expo[pos], 6'($urandom));
    send_item(CMD_PUSH, INT_BOTTOM, held_expo[pos], 6'($urandom));
    send_item(CMD_READ, $urandom, $urandom, 6'd63);
    pos = $urandom_range(0, TERM_SLOTS - 1);
    send_item(CMD_PUSH, -held_coef[pos], held_expo[pos], 6'($urandom));
    send_item(CMD_READ, $urandom, $urandom, 6'd63);
    send_item(CMD_PUSH, 32'sd3, e, 6'($urandom));
    repeat (40) send_item(CMD_READ, $urandom, $urandom, 6'($urandom_range(0, 63)));
    send_item(CMD_CLEAR, $urandom, $urandom, 6'($urandom));
    wait_table_idle();
  endtask

  task automatic test_random_mix();
    int sel;
    logic signed [31:0] e;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 199);
      if (sel < 118) begin
        e = pick_exponent();
        send_item(CMD_PUSH, pick_coefficient(e), e, 6'($urandom));
      end else if (sel < 190) begin
        send_item(CMD_READ, $urandom, $urandom, pick_index());
      end else if (sel < 197) begin
        send_item(CMD_SPARE, $urandom, $urandom, 6'($urandom));
      end else begin
        send_item(CMD_CLEAR, $urandom, $urandom, 6'($urandom));
      end
      if (n == RANDOM_ITEMS / 2) wait_table_idle();
    end
    wait_table_idle();
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_PUSH;
    in_new_coefficient <= '0;
    in_new_exponent <= '0;
    in_term_index <= '0;
    no_gap_run = 0;
    held_terms = 0;
    foreach (cmd_seen[k]) cmd_seen[k] = 0;
    expo_pool[0] = INT_TOP;
    expo_pool[1] = INT_BOTTOM;
    expo_pool[2] = 32'sd0;
    expo_pool[3] = -32'sd1;
    expo_pool[4] = 32'sd1;
    for (int k = 5; k < 96; k++)
      expo_pool[k] = (k % 2 == 0) ? int'($urandom) : int'($urandom_range(0, 400)) - 200;

    reset_block();
    test_empty_table();
    test_push_extremes();
    test_full_table();
    test_random_mix();
    test_full_table();

    wait_table_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("items: %0d push, %0d read, %0d clear, %0d unused; %0d results checked",
             cmd_seen[CMD_PUSH], cmd_seen[CMD_READ], cmd_seen[CMD_CLEAR], cmd_seen[CMD_SPARE],
             answers_checked);
    $display("statuses: ok %0d, zero %0d, full %0d, range %0d, saturated %0d; %0d errors",
             status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_FULL],
             status_seen[ST_RANGE], status_seen[ST_SAT], errors);
    if (errors == 0 && table_answers.size() == 0) begin
      $display("sorted_sparse_term_table_unit regression: pass");
    end else begin
      $display("sorted_sparse_term_table_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sorted_sparse_term_table_unit.f -----
+incdir+hw/rtl
hw/rtl/sstt_pkg.sv
hw/rtl/sstt_arith.sv
hw/rtl/sorted_sparse_term_table_unit.sv
tb/tb_sorted_sparse_term_table_unit.sv
